/* rtl/crsf_pkg.sv */
// Shared constants, types and the CRC-8 helper for the CRSF RC channel frame builder.
package crsf_pkg;

  localparam int unsigned ChCount      = 16;
  localparam int unsigned ChWidth      = 11;
  localparam int unsigned PayloadBits  = ChCount * ChWidth;
  localparam int unsigned PayloadBytes = PayloadBits / 8;
  localparam int unsigned FrameBytes   = PayloadBytes + 4;

  localparam logic [7:0] FRAME_SYNC = 8'hC8;
  localparam logic [7:0] LEN_BYTE   = 8'(PayloadBytes + 2);
  localparam logic [7:0] TYPE_BYTE  = 8'h16;
  localparam logic [7:0] CRC_POLY   = 8'hD5;

  localparam logic [ChWidth-1:0] CENTRE_VALUE = 11'd992;

  // Byte positions within a frame.
  localparam logic [4:0] IDX_SYNC = 5'd0;
  localparam logic [4:0] IDX_LEN  = 5'd1;
  localparam logic [4:0] IDX_TYPE = 5'd2;
  localparam logic [4:0] IDX_CRC  = 5'(FrameBytes - 1);

  typedef logic [PayloadBits-1:0] payload_t;
  typedef logic [ChWidth-1:0]     chan_t;

  // One frame handed from the collector to the serializer.
  typedef struct packed {
    logic     valid;
    payload_t payload;
  } frame_req_t;

  // MSB-first CRC-8, one byte per call.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

/* rtl/crsf_rc_channel_frame_builder_unit.sv */
// With the serializer idle, the last channel word is written to the frame queue; the serializer
// then loads the payload from the queue and registers the sync byte as the first frame byte.
// Throughput: one channel word per cycle in while the frame queue has room; the serializer sends
// one byte per cycle within a frame while out_tready is high, then pauses to load the next payload.
// The two-entry frame queue lets the next frame's channels arrive while one is sent.
// Reset (rst_n low, synchronous) empties the queue, clears the channel count and
// drops any frame in flight; no clearing pass is needed.
module crsf_rc_channel_frame_builder_unit (
  input  logic        clk,
  input  logic        rst_n,
  // Channel input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [10:0] channel value, [15:11] zero
  input  logic        in_tlast,   // last_channel
  // Frame byte output stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] frame_byte
  output logic        out_tlast   // frame_end
);
  import crsf_pkg::*;

  frame_req_t push;
  logic       push_ready;
  logic       pop_valid;
  payload_t   pop_data;
  logic       pop_ready;

  // The collector keeps the channel slots and builds the 176-bit payload, with the
  // centre value in every slot the current frame did not supply, on the last word.
  crsf_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_value   (in_tdata[ChWidth-1:0]),
    .in_tlast   (in_tlast),
    .push       (push),
    .push_ready (push_ready)
  );

  // Finished payloads wait here so a stalled output does not block channel intake.
  crsf_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready)
  );

  // The serializer walks the frame byte by byte, folding type and payload bytes
  // into the CRC as they go out, and ends with the CRC byte marked by tlast.
  crsf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .pop_valid  (pop_valid),
    .pop_data   (pop_data),
    .pop_ready  (pop_ready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

endmodule

/* rtl/crsf_front.sv */
// Channel collector: stores incoming channel words and emits a packed payload on the last one.
module crsf_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  crsf_pkg::chan_t     in_value,
  input  logic                in_tlast,
  output crsf_pkg::frame_req_t push,
  input  logic                push_ready
);
  import crsf_pkg::*;

  chan_t      store_r [ChCount];
  logic [4:0] loaded_r;
  logic [4:0] loaded_nxt;
  logic       accept;
  logic       room;

  assign in_tready = push_ready;
  assign accept    = in_tvalid && in_tready;
  assign room      = (loaded_r < 5'(ChCount));

  always_comb begin
    loaded_nxt = loaded_r;
    if (accept) begin
      if (in_tlast) begin
        loaded_nxt = '0;
      end else if (room) begin
        loaded_nxt = loaded_r + 5'd1;
      end
    end
  end

  // Slots below the count come from the store, the current word takes the next slot,
  // and everything above it is sent as the centre value.
  always_comb begin
    push.valid   = accept && in_tlast;
    push.payload = '0;
    for (int i = 0; i < ChCount; i++) begin
      if (5'(i) < loaded_r) begin
        push.payload[i*ChWidth +: ChWidth] = store_r[i];
      end else if (5'(i) == loaded_r) begin
        push.payload[i*ChWidth +: ChWidth] = in_value;
      end else begin
        push.payload[i*ChWidth +: ChWidth] = CENTRE_VALUE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      loaded_r <= '0;
    end else begin
      loaded_r <= loaded_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && room) begin
      store_r[loaded_r[3:0]] <= in_value;
    end
  end

endmodule

/* rtl/crsf_fifo.sv */
// Two-entry frame queue between the collector and the serializer.
module crsf_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  crsf_pkg::frame_req_t push,
  output logic                 push_ready,
  output logic                 pop_valid,
  output crsf_pkg::payload_t   pop_data,
  input  logic                 pop_ready
);
  import crsf_pkg::*;

  payload_t   mem_r [2];
  logic       wr_ptr_r;
  logic       wr_ptr_nxt;
  logic       rd_ptr_r;
  logic       rd_ptr_nxt;
  logic [1:0] count_r;
  logic [1:0] count_nxt;
  logic       do_push;
  logic       do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_data   = mem_r[rd_ptr_r];
  assign do_push    = push.valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 2'd1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push.payload;
    end
  end

endmodule

/* rtl/crsf_back.sv */
// Frame serializer: sends header, payload bytes and a running CRC-8 one byte per word.
module crsf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               pop_valid,
  input  crsf_pkg::payload_t pop_data,
  output logic               pop_ready,
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,
  output logic               out_tlast
);
  import crsf_pkg::*;

  logic       busy_r,  busy_nxt;
  logic [4:0] idx_r,   idx_nxt;
  payload_t   shift_r, shift_nxt;
  logic [7:0] crc_r,   crc_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] data_r,  data_nxt;
  logic       last_r,  last_nxt;
  logic       load;

  assign pop_ready  = !busy_r;
  assign out_tvalid = valid_r;
  assign out_tdata  = data_r;
  assign out_tlast  = last_r;
  assign load       = busy_r && (!valid_r || out_tready);

  always_comb begin
    busy_nxt  = busy_r;
    idx_nxt   = idx_r;
    shift_nxt = shift_r;
    crc_nxt   = crc_r;
    valid_nxt = valid_r;
    data_nxt  = data_r;
    last_nxt  = last_r;

    if (!busy_r && pop_valid) begin
      busy_nxt  = 1'b1;
      idx_nxt   = IDX_SYNC;
      shift_nxt = pop_data;
      crc_nxt   = '0;
    end

    if (valid_r && out_tready) begin
      valid_nxt = 1'b0;
    end

    if (load) begin
      valid_nxt = 1'b1;
      last_nxt  = 1'b0;
      idx_nxt   = idx_r + 5'd1;
      case (idx_r)
        IDX_SYNC: data_nxt = FRAME_SYNC;
        IDX_LEN:  data_nxt = LEN_BYTE;
        IDX_TYPE: begin
          data_nxt = TYPE_BYTE;
          crc_nxt  = crc8_update(crc_r, TYPE_BYTE);
        end
        IDX_CRC: begin
          data_nxt = crc_r;
          last_nxt = 1'b1;
          busy_nxt = 1'b0;
        end
        default: begin
          data_nxt  = shift_r[7:0];
          crc_nxt   = crc8_update(crc_r, shift_r[7:0]);
          shift_nxt = shift_r >> 8;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      valid_r <= 1'b0;
    end else begin
      busy_r  <= busy_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r   <= idx_nxt;
    shift_r <= shift_nxt;
    crc_r   <= crc_nxt;
    data_r  <= data_nxt;
    last_r  <= last_nxt;
  end

endmodule

/* rtl/crsf_checker.sv */
// Port-level checker for the frame builder, bound to the top level.
module crsf_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_tvalid,
  input logic       out_tready,
  input logic [7:0] out_tdata,
  input logic       out_tlast
);
  import crsf_pkg::*;

  logic [4:0] pos_r;

  // Position of the next output word within its frame, tracked from the port.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= IDX_SYNC;
    end else if (out_tvalid && out_tready) begin
      pos_r <= out_tlast ? IDX_SYNC : pos_r + 5'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("output word changed while stalled");

  a_sync: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && pos_r == IDX_SYNC |-> out_tdata == FRAME_SYNC)
    else $error("frame does not start with the sync byte");

  a_header: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (pos_r == IDX_LEN || pos_r == IDX_TYPE) |->
      out_tdata == ((pos_r == IDX_LEN) ? LEN_BYTE : TYPE_BYTE))
    else $error("wrong length or type byte");

  a_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tlast == (pos_r == IDX_CRC))
    else $error("frame end mark not on the 26th byte");

endmodule

bind crsf_rc_channel_frame_builder_unit crsf_checker u_crsf_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);
